FILE: design/ftss_pkg.sv
// ----------------------------------------------------------------------------
// ftss_pkg
// ----------------------------------------------------------------------------
// Shared types, character codes and constants of the frame tag shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package ftss_pkg;

    // Field and register widths.
    localparam int DELAY_W        = 28;
    localparam int RATE_W         = 8;
    localparam int CHAR_W         = 8;
    localparam int CODE_W         = 3;
    localparam int ACC_W          = 32;
    localparam int SUM_W          = ACC_W + 1;
    localparam int FRAME_W        = 31;
    localparam int APB_DW         = 32;
    localparam int ADDR_W         = 3;
    localparam int MAX_DIGITS_DEF = 10;

    // Frame offset: ((delay / 100) * rate) / 10, done on the magnitude by
    // reciprocal multiplies that are exact over the whole delay range.
    localparam int                  PA_W      = 2 * DELAY_W;
    localparam int                  Q1_W      = 21;
    localparam int                  PB_W      = Q1_W + RATE_W;
    localparam int                  PC_W      = 2 * PB_W;
    localparam int                  OFS_W     = 26;
    localparam int                  SHIFT_100 = 34;
    localparam int                  SHIFT_10  = 32;
    localparam logic [DELAY_W-1:0]  RECIP_100 = 28'd171798692;
    localparam logic [PB_W-1:0]     RECIP_10  = 29'd429496730;

    // Cycles for a new configuration to reach the offset register.
    localparam logic [1:0] SETTLE_CYC = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [CODE_W-1:0] {
        ERR_NONE             = 3'd0,
        ERR_NEG_OFFSET       = 3'd1,
        ERR_UNTERMINATED     = 3'd2,
        ERR_END_BEFORE_START = 3'd3,
        ERR_MISSING_END      = 3'd4,
        ERR_OVERFLOW         = 3'd5
    } err_code_t;

    typedef enum logic {
        REG_DELAY_MS   = 1'b0,
        REG_FRAME_RATE = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_BRACE  = 2'd1,
        MODE_DIGITS = 2'd2,
        MODE_SKIP   = 2'd3
    } parse_mode_t;

    typedef enum logic [1:0] {
        PLAN_NONE  = 2'd0,
        PLAN_CHARS = 2'd1,
        PLAN_ERR   = 2'd2,
        PLAN_NUM   = 2'd3
    } plan_t;

    typedef enum logic [2:0] {
        OSEL_ERR   = 3'd0,
        OSEL_C0    = 3'd1,
        OSEL_C1    = 3'd2,
        OSEL_OPEN  = 3'd3,
        OSEL_DIGIT = 3'd4,
        OSEL_CLOSE = 3'd5
    } out_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECIDE = 2'd1,
        ST_CONV   = 2'd2,
        ST_EMIT   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic     load_item;
        logic     decide;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        plan_t plan_now;
        plan_t plan;
        logic  two_chars;
        logic  conv_busy;
    } dp_status_t;

    // Largest frame number accepted: min(2^31-1, 10^max_digits - 1).
    function automatic logic [ACC_W-1:0] value_limit(input int max_digits);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < max_digits && i < 18; i++)
        begin
            p = p * 64'd10;
        end
        if ((p - 64'd1) > 64'h7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        return 32'(p - 64'd1);
    endfunction

    // Decimal digits needed for the largest accepted frame number.
    function automatic int num_digits(input int max_digits);
        return (max_digits < 10) ? max_digits : 10;
    endfunction

endpackage

`default_nettype wire

FILE: design/ftss_if.sv
// ----------------------------------------------------------------------------
// ftss_char_if / ftss_res_if
// ----------------------------------------------------------------------------
// Valid/ready channels for text items in and result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftss_char_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_char;

    modport source (output valid, output action, output in_char, input ready);
    modport sink   (input valid, input action, input in_char, output ready);
endinterface

interface ftss_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_char, output status, output last, input ready);
    modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: design/ftss_ctrl.sv
// ----------------------------------------------------------------------------
// ftss_ctrl
// ----------------------------------------------------------------------------
// Sequencer: takes items, starts the decision and conversion, and walks the
// result items of each input item through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftss_ctrl import ftss_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int NDIG       = num_digits(MAX_DIGITS),
    parameter int DIG_IW     = $clog2(NDIG)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_wr,
    input  dp_status_t        status,
    input  logic [DIG_IW-1:0] top_digit,
    output ctrl_cmd_t         cmd,
    output logic [DIG_IW-1:0] dig_idx
);

    localparam int POS_W = $clog2(NDIG + 2);

    ctrl_state_t      state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       settle_reg, settle_next;

    logic             can_load;
    logic             is_last;
    out_sel_t         sel;
    logic [POS_W-1:0] close_pos;
    logic [POS_W-1:0] digit_pos;

    assign can_load  = !out_valid_reg || out_ready;
    assign close_pos = POS_W'(top_digit) + POS_W'(2);
    // Digits leave most significant first: position 1 carries the top digit.
    assign digit_pos = POS_W'(top_digit) + POS_W'(1) - pos_reg;
    assign dig_idx   = digit_pos[DIG_IW-1:0];
    assign out_valid = out_valid_reg;

    // Which result the current position stands for, and whether it ends the item.
    always_comb
    begin
        sel     = OSEL_ERR;
        is_last = 1'b1;
        case (status.plan)
            PLAN_ERR:
            begin
                sel     = OSEL_ERR;
                is_last = 1'b1;
            end
            PLAN_CHARS:
            begin
                sel     = (pos_reg == '0) ? OSEL_C0 : OSEL_C1;
                is_last = (pos_reg == POS_W'(status.two_chars));
            end
            PLAN_NUM:
            begin
                if (pos_reg == '0)
                begin
                    sel = OSEL_OPEN;
                end
                else if (pos_reg == close_pos)
                begin
                    sel = OSEL_CLOSE;
                end
                else
                begin
                    sel = OSEL_DIGIT;
                end
                is_last = (pos_reg == close_pos);
            end
            default:
            begin
                sel     = OSEL_ERR;
                is_last = 1'b1;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.decide    = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_sel   = sel;
        cmd.out_last  = is_last;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = (settle_reg == '0);
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.out_load = can_load;
                in_ready     = (settle_reg == '0) && can_load && is_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load_item = in_valid && in_ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load_item)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (status.plan_now)
                    PLAN_NONE: state_next = ST_IDLE;
                    PLAN_NUM:  state_next = ST_CONV;
                    default:   state_next = ST_EMIT;
                endcase
            end
            ST_CONV:
            begin
                if (!status.conv_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_load && is_last)
                begin
                    state_next = cmd.load_item ? ST_DECIDE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result position, output valid and configuration settle counter.
    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        settle_next    = settle_reg;
        if (cmd.decide)
        begin
            pos_next = '0;
        end
        else if (cmd.out_load)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_wr)
        begin
            settle_next = SETTLE_CYC;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            settle_reg    <= SETTLE_CYC;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            settle_reg    <= settle_next;
        end
    end

    a_ready_states: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE || state_reg == ST_EMIT))
        else $error("item taken while an item is still being decided or converted");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !in_ready)
        else $error("item taken before the new offset has settled");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= POS_W'(NDIG + 1)))
        else $error("result position ran past the longest number");

    a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg != ST_EMIT))
        else $error("still emitting after the final result of an item");

endmodule

`default_nettype wire

FILE: design/ftss_dp.sv
// ----------------------------------------------------------------------------
// ftss_dp
// ----------------------------------------------------------------------------
// Datapath: offset pipeline, parse state, item decision, binary to decimal
// converter and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftss_dp import ftss_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int NDIG       = num_digits(MAX_DIGITS),
    parameter int DIG_IW     = $clog2(NDIG)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [DELAY_W-1:0] delay_cfg,
    input  logic [RATE_W-1:0]         rate_cfg,
    input  logic                      action,
    input  logic [CHAR_W-1:0]         in_char,
    input  ctrl_cmd_t                 cmd,
    input  logic [DIG_IW-1:0]         dig_idx,
    output dp_status_t                status,
    output logic [DIG_IW-1:0]         top_digit,
    output logic [CHAR_W-1:0]         out_char,
    output logic [CODE_W-1:0]         out_status,
    output logic                      out_last
);

    localparam logic [ACC_W-1:0] LIMIT = value_limit(MAX_DIGITS);
    localparam int BIN_W = $clog2(SUM_W'(LIMIT) + SUM_W'(1));
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(BIN_W + 1);
    localparam int MUL_W = ACC_W + 4;

    // Offset pipeline, rerun every cycle from the configuration registers.
    logic [DELAY_W-1:0] mag;
    logic [PA_W-1:0]    prod_a_reg;
    logic [PB_W-1:0]    prod_b_reg;
    logic [PC_W-1:0]    prod_c_reg;
    logic               sign_a_reg, sign_b_reg, sign_c_reg;
    logic [OFS_W-1:0]   offset;
    logic               off_neg;
    logic               passthru;

    // Item and parse state.
    logic               action_reg;
    logic [CHAR_W-1:0]  char_reg;
    parse_mode_t        mode_reg, mode_next;
    logic [FRAME_W-1:0] ff_reg, ff_next, sf_reg, sf_next;
    logic               fs_reg, fs_next, ss_reg, ss_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               lnl_reg, lnl_next;
    logic               err_reg, err_next;
    err_code_t          err_code_reg, err_code_next;

    // Decision results held for emission.
    plan_t              plan_now, plan_reg;
    err_code_t          code_now, code_reg;
    logic [CHAR_W-1:0]  c0_now, c0_reg, c1_now, c1_reg;
    logic               two_now, two_reg;

    logic               is_dig;
    logic               pair_bad;
    err_code_t          pair_code;
    logic [SUM_W-1:0]   sum;
    logic               close_bad;
    logic               do_close;
    logic [MUL_W-1:0]   acc_times;

    // Converter.
    logic [BCD_W-1:0]   bcd_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BCD_W-1:0]   bcd_adj;
    logic [BCD_W+BIN_W-1:0] shifted;
    logic [3:0]         nib;
    logic [3:0]         out_nib;

    logic [CHAR_W-1:0]  out_char_reg;
    logic [CODE_W-1:0]  out_status_reg;
    logic               out_last_reg;

    // ---- offset ----
    assign mag      = delay_cfg[DELAY_W-1] ? (~delay_cfg + DELAY_W'(1)) : delay_cfg;
    assign offset   = prod_c_reg[SHIFT_10 +: OFS_W];
    assign off_neg  = sign_c_reg && (offset != '0);
    assign passthru = (delay_cfg == '0) || (rate_cfg == '0);

    always_ff @(posedge clk)
    begin
        prod_a_reg <= PA_W'(mag) * PA_W'(RECIP_100);
        sign_a_reg <= delay_cfg[DELAY_W-1];
        prod_b_reg <= PB_W'(prod_a_reg[SHIFT_100 +: Q1_W]) * PB_W'(rate_cfg);
        sign_b_reg <= sign_a_reg;
        prod_c_reg <= PC_W'(prod_b_reg) * PC_W'(RECIP_10);
        sign_c_reg <= sign_b_reg;
    end

    // ---- item decision ----
    assign is_dig    = char_reg inside {[CH_ZERO:CH_NINE]};
    assign pair_bad  = fs_reg && (!ss_reg || (ff_reg > sf_reg));
    assign pair_code = ss_reg ? ERR_END_BEFORE_START : ERR_MISSING_END;
    assign sum       = SUM_W'(acc_reg) + SUM_W'(offset);
    assign close_bad = (acc_reg > LIMIT) || (sum > SUM_W'(LIMIT));
    assign acc_times = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1)
                       + MUL_W'(char_reg[3:0]);

    always_comb
    begin
        mode_next     = mode_reg;
        ff_next       = ff_reg;
        sf_next       = sf_reg;
        fs_next       = fs_reg;
        ss_next       = ss_reg;
        acc_next      = acc_reg;
        lnl_next      = lnl_reg;
        err_next      = err_reg;
        err_code_next = err_code_reg;
        plan_now      = PLAN_NONE;
        code_now      = ERR_NONE;
        c0_now        = char_reg;
        c1_now        = CH_NL;
        two_now       = 1'b0;
        do_close      = 1'b0;

        if (err_reg)
        begin
            plan_now = PLAN_ERR;
            code_now = err_code_reg;
        end
        else if (passthru)
        begin
            if (!action_reg)
            begin
                plan_now = PLAN_CHARS;
            end
        end
        else if (off_neg)
        begin
            plan_now = PLAN_ERR;
            code_now = ERR_NEG_OFFSET;
        end
        else if (action_reg)
        begin
            case (mode_reg)
                MODE_DIGITS, MODE_SKIP:
                begin
                    plan_now = PLAN_ERR;
                    code_now = ERR_UNTERMINATED;
                end
                MODE_BRACE:
                begin
                    // The pending brace passes, and then the closing newline.
                    if (pair_bad)
                    begin
                        plan_now = PLAN_ERR;
                        code_now = pair_code;
                    end
                    else
                    begin
                        plan_now = PLAN_CHARS;
                        c0_now   = CH_OPEN;
                        two_now  = 1'b1;
                    end
                end
                default:
                begin
                    if (!lnl_reg)
                    begin
                        plan_now = PLAN_CHARS;
                        c0_now   = CH_NL;
                    end
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_BRACE:
                begin
                    if (is_dig)
                    begin
                        acc_next  = ACC_W'(char_reg[3:0]);
                        mode_next = MODE_DIGITS;
                    end
                    else if (pair_bad)
                    begin
                        plan_now = PLAN_ERR;
                        code_now = pair_code;
                    end
                    else
                    begin
                        // The brace was plain text after all.
                        plan_now = PLAN_CHARS;
                        c0_now   = CH_OPEN;
                        fs_next  = 1'b0;
                        ss_next  = 1'b0;
                        lnl_next = 1'b0;
                        if (char_reg != CH_OPEN)
                        begin
                            mode_next = MODE_TEXT;
                            two_now   = 1'b1;
                            c1_now    = char_reg;
                            lnl_next  = (char_reg == CH_NL);
                        end
                    end
                end
                MODE_DIGITS:
                begin
                    if (is_dig)
                    begin
                        // Saturate just above the limit so that the close reports overflow.
                        acc_next = (acc_times > MUL_W'(LIMIT)) ? (LIMIT + ACC_W'(1))
                                                                : acc_times[ACC_W-1:0];
                    end
                    else if (char_reg == CH_CLOSE)
                    begin
                        do_close = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_SKIP:
                begin
                    do_close = (char_reg == CH_CLOSE);
                end
                default:
                begin
                    if (char_reg == CH_OPEN)
                    begin
                        mode_next = MODE_BRACE;
                    end
                    else if (pair_bad)
                    begin
                        plan_now = PLAN_ERR;
                        code_now = pair_code;
                    end
                    else
                    begin
                        plan_now = PLAN_CHARS;
                        fs_next  = 1'b0;
                        ss_next  = 1'b0;
                        lnl_next = (char_reg == CH_NL);
                    end
                end
            endcase
        end

        if (do_close)
        begin
            mode_next = MODE_TEXT;
            if (close_bad)
            begin
                plan_now = PLAN_ERR;
                code_now = ERR_OVERFLOW;
            end
            else
            begin
                plan_now = PLAN_NUM;
                if (!fs_reg)
                begin
                    ff_next = sum[FRAME_W-1:0];
                    fs_next = 1'b1;
                end
                else
                begin
                    // A third or later number replaces the second one.
                    sf_next = sum[FRAME_W-1:0];
                    ss_next = 1'b1;
                end
            end
        end

        if (plan_now == PLAN_ERR)
        begin
            err_next      = 1'b1;
            err_code_next = code_now;
        end

        // End of text always returns the stream to its start.
        if (action_reg)
        begin
            mode_next     = MODE_TEXT;
            fs_next       = 1'b0;
            ss_next       = 1'b0;
            lnl_next      = 1'b1;
            err_next      = 1'b0;
            err_code_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TEXT;
            fs_reg       <= 1'b0;
            ss_reg       <= 1'b0;
            lnl_reg      <= 1'b1;
            err_reg      <= 1'b0;
            err_code_reg <= ERR_NONE;
            plan_reg     <= PLAN_NONE;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.decide)
            begin
                mode_reg     <= mode_next;
                fs_reg       <= fs_next;
                ss_reg       <= ss_next;
                lnl_reg      <= lnl_next;
                err_reg      <= err_next;
                err_code_reg <= err_code_next;
                plan_reg     <= plan_now;
            end
            if (cmd.decide && (plan_now == PLAN_NUM))
            begin
                cnt_reg <= CNT_W'(BIN_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action;
            char_reg   <= in_char;
        end
        if (cmd.decide)
        begin
            ff_reg   <= ff_next;
            sf_reg   <= sf_next;
            acc_reg  <= acc_next;
            code_reg <= code_now;
            c0_reg   <= c0_now;
            c1_reg   <= c1_now;
            two_reg  <= two_now;
        end
    end

    // ---- binary to decimal, one bit per cycle (shift and add three) ----
    always_comb
    begin
        nib = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            nib = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
        end
        shifted = {bcd_adj, bin_reg} << 1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide && (plan_now == PLAN_NUM))
        begin
            bcd_reg <= '0;
            bin_reg <= sum[BIN_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            bcd_reg <= shifted[BIN_W +: BCD_W];
            bin_reg <= shifted[BIN_W-1:0];
        end
    end

    // Most significant nonzero digit; a zero value still shows one digit.
    always_comb
    begin
        top_digit = '0;
        for (int i = 1; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                top_digit = DIG_IW'(i);
            end
        end
    end

    // ---- output payload ----
    assign out_nib = bcd_reg[4*dig_idx +: 4];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= (cmd.out_sel == OSEL_ERR) ? code_reg : ERR_NONE;
            out_last_reg   <= cmd.out_last;
            case (cmd.out_sel)
                OSEL_ERR:   out_char_reg <= CH_NUL;
                OSEL_C0:    out_char_reg <= c0_reg;
                OSEL_C1:    out_char_reg <= c1_reg;
                OSEL_OPEN:  out_char_reg <= CH_OPEN;
                OSEL_DIGIT: out_char_reg <= CH_ZERO + CHAR_W'(out_nib);
                OSEL_CLOSE: out_char_reg <= CH_CLOSE;
                default:    out_char_reg <= CH_NUL;
            endcase
        end
    end

    assign out_char   = out_char_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    assign status.plan_now  = plan_now;
    assign status.plan      = plan_reg;
    assign status.two_chars = two_reg;
    assign status.conv_busy = (cnt_reg != '0);

endmodule

`default_nettype wire

FILE: design/frame_tag_subtitle_shifter.sv
// ----------------------------------------------------------------------------
// frame_tag_subtitle_shifter
// ----------------------------------------------------------------------------
// Flow: a text item is accepted, then decided, then loaded into the output
// register as its first result; a closing brace first runs the
// one-bit-per-cycle decimal converter. Results then leave at one per cycle
// while the output is ready, and a new item can be taken with the final
// result of the last one. rst_n clears the control and configuration registers and the stream state.
// ----------------------------------------------------------------------------
`default_nettype none

// The block rewrites a character stream in which frame numbers stand as
// {digits}. Each number is shifted by the frame offset ((delay/100)*rate)/10
// and written back in decimal; ordinary characters pass through, and end of
// text appends a newline where it did not end in one. A zero delay or rate passes the text through unparsed.
//
// Structure:
//   - An APB register file here holds the delay and the frame rate.
//   - ftss_dp computes the offset with three registered multiplies, two by
//     reciprocals, keeps the parse state, decides what each item produces
//     and converts a shifted number to decimal digits.
//   - ftss_ctrl takes items, steps the datapath, and walks the result items
//     of each input item through the output register.
//
// After a configuration write the block takes no item until the new offset
// has settled through the multiplier registers. An item that ends in an
// error, or that arrives while an error is held, gives a single result
// carrying the status code and a zero character. End of text always returns
// the stream state to its start, which also clears a held error.

module frame_tag_subtitle_shifter import ftss_pkg::*; #(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ftss_char_if.sink         char_ch,
    ftss_res_if.source        res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NDIG   = num_digits(MAX_DIGITS);
    localparam int DIG_IW = $clog2(NDIG);

    logic signed [DELAY_W-1:0] delay_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic                      cfg_wr;
    reg_idx_t                  reg_sel;

    ctrl_cmd_t                 cmd;
    dp_status_t                status;
    logic [DIG_IW-1:0]         top_digit;
    logic [DIG_IW-1:0]         dig_idx;

    // Registers sit at byte addresses 0 and 4, so only the upper address bit
    // picks one of them.
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            rate_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_DELAY_MS:   delay_reg <= pwdata[DELAY_W-1:0];
                REG_FRAME_RATE: rate_reg  <= pwdata[RATE_W-1:0];
                default:        rate_reg  <= rate_reg;
            endcase
        end
    end

    // Reads return the delay sign extended and the rate zero extended.
    always_comb
    begin
        case (reg_sel)
            REG_DELAY_MS:   prdata = {{(APB_DW-DELAY_W){delay_reg[DELAY_W-1]}}, delay_reg};
            REG_FRAME_RATE: prdata = APB_DW'(rate_reg);
            default:        prdata = '0;
        endcase
    end

    ftss_ctrl #(
        .MAX_DIGITS (MAX_DIGITS),
        .NDIG       (NDIG),
        .DIG_IW     (DIG_IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_ch.valid),
        .in_ready  (char_ch.ready),
        .out_valid (res_ch.valid),
        .out_ready (res_ch.ready),
        .cfg_wr    (cfg_wr),
        .status    (status),
        .top_digit (top_digit),
        .cmd       (cmd),
        .dig_idx   (dig_idx)
    );

    ftss_dp #(
        .MAX_DIGITS (MAX_DIGITS),
        .NDIG       (NDIG),
        .DIG_IW     (DIG_IW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .delay_cfg  (delay_reg),
        .rate_cfg   (rate_reg),
        .action     (char_ch.action),
        .in_char    (char_ch.in_char),
        .cmd        (cmd),
        .dig_idx    (dig_idx),
        .status     (status),
        .top_digit  (top_digit),
        .out_char   (res_ch.out_char),
        .out_status (res_ch.status),
        .out_last   (res_ch.last)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// ----------------------------------------------------------------------------
// Self-checking bench for the frame tag shifter. A queue of text items feeds
// a valid/ready driver. A local predictor rewrites every accepted item into
// the result items the block should return, and a monitor compares each
// returned item field by field. The run steps through several delay and
// frame rate settings, including passthrough, negative and large shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import ftss_pkg::*;;

    // The shifted frame number may not exceed 2^31-1, nor the largest value
    // that fits in FRAME_DIGITS decimal digits.
    localparam int                FRAME_DIGITS = MAX_DIGITS_DEF;
    localparam longint unsigned   DIGIT_CEIL   = 64'd10 ** FRAME_DIGITS;
    localparam longint unsigned   FRAME_LIMIT  =
        (DIGIT_CEIL - 64'd1 > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : DIGIT_CEIL - 64'd1;

    // Cycles to let pass after the last expected item, so that a closing
    // brace still in decimal conversion cannot overlap a register write.
    localparam int DRAIN_CYCLES = 64;
    // Hard stop of the run, far beyond the slowest correct run.
    localparam int RUN_LIMIT_NS = 5_000_000;

    // One text item as handed to the driver.
    typedef struct packed {
        logic              eot;
        logic [CHAR_W-1:0] ch;
    } text_item_t;

    // One result item as the block should return it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CODE_W-1:0] status;
        logic              last;
    } shifted_char_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ftss_char_if char_if();
    ftss_res_if  res_if();

    frame_tag_subtitle_shifter #(
        .MAX_DIGITS(FRAME_DIGITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_if),
        .res_ch  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and scoreboard storage.
    text_item_t    text_q[$];
    shifted_char_t shifted_q[$];
    shifted_char_t item_out_q[$];
    text_item_t    next_item;
    shifted_char_t want;
    int            queued_items;
    int            items_taken;
    bit            failed;

    // Predictor copy of the registers.
    logic [DELAY_W-1:0] cfg_delay;
    logic [RATE_W-1:0]  cfg_rate;

    // Predictor copy of the stream state.
    parse_mode_t        mode_s;
    logic [FRAME_W-1:0] start_frame;
    bit                 start_seen;
    logic [FRAME_W-1:0] end_frame;
    bit                 end_seen;
    logic [ACC_W-1:0]   digit_acc;
    bit                 ended_nl;
    bit                 err_held;
    err_code_t          held_code;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // End of text puts the whole stream state back to its start, including a
    // held error. The registers keep their values.
    task automatic clear_stream();
        mode_s      = MODE_TEXT;
        start_frame = '0;
        start_seen  = 1'b0;
        end_frame   = '0;
        end_seen    = 1'b0;
        digit_acc   = '0;
        ended_nl    = 1'b1;
        err_held    = 1'b0;
        held_code   = ERR_NONE;
    endtask

    // Frame offset with both divisions truncating toward zero.
    function automatic longint frame_shift();
        longint tenths;
        tenths = longint'($signed(cfg_delay)) / 100;
        return (tenths * longint'(cfg_rate)) / 10;
    endfunction

    // Passes one ordinary character. The start/end pair collected since the
    // previous ordinary character must be complete and in order first.
    function automatic err_code_t emit_plain(input logic [CHAR_W-1:0] c);
        if (start_seen && end_seen && start_frame > end_frame)
            return ERR_END_BEFORE_START;
        if (start_seen && !end_seen)
            return ERR_MISSING_END;
        item_out_q.push_back('{c, ERR_NONE, 1'b0});
        ended_nl   = (c == CH_NL);
        start_seen = 1'b0;
        end_seen   = 1'b0;
        return ERR_NONE;
    endfunction

    // Closes a number: adds the shift and writes it back in decimal between
    // braces. A third or later number in one caption replaces the second.
    function automatic err_code_t emit_tag(input longint shift);
        longint unsigned total;
        string           txt;
        mode_s = MODE_TEXT;
        total  = 64'(digit_acc) + 64'(shift);
        if (64'(digit_acc) > FRAME_LIMIT || total > FRAME_LIMIT)
            return ERR_OVERFLOW;
        if (!start_seen)
        begin
            start_frame = total[FRAME_W-1:0];
            start_seen  = 1'b1;
        end
        else
        begin
            end_frame = total[FRAME_W-1:0];
            end_seen  = 1'b1;
        end
        txt = $sformatf("%0d", total);
        item_out_q.push_back('{CH_OPEN, ERR_NONE, 1'b0});
        foreach (txt[i])
            item_out_q.push_back('{txt[i], ERR_NONE, 1'b0});
        item_out_q.push_back('{CH_CLOSE, ERR_NONE, 1'b0});
        return ERR_NONE;
    endfunction

    // Works out the result items of one accepted text item and appends them
    // to the expected stream, the final one of the item carrying last.
    task automatic rewrite_item(input logic eot, input logic [CHAR_W-1:0] c);
        err_code_t       err;
        longint          shift;
        longint unsigned grown;
        bit              digit;
        int              n;
        item_out_q.delete();
        err   = ERR_NONE;
        shift = frame_shift();
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (err_held)
            err = held_code;
        else if (cfg_delay == '0 || cfg_rate == '0)
        begin
            // Passthrough: no parsing, no checks, no newline at end of text.
            if (!eot)
                item_out_q.push_back('{c, ERR_NONE, 1'b0});
        end
        else if (shift < 0)
            err = ERR_NEG_OFFSET;
        else if (eot)
        begin
            if (mode_s == MODE_DIGITS || mode_s == MODE_SKIP)
                err = ERR_UNTERMINATED;
            else
            begin
                // A lone brace at end of text is an ordinary character.
                if (mode_s == MODE_BRACE)
                    err = emit_plain(CH_OPEN);
                if (err == ERR_NONE && !ended_nl)
                    item_out_q.push_back('{CH_NL, ERR_NONE, 1'b0});
            end
        end
        else
        begin
            case (mode_s)
                MODE_BRACE:
                begin
                    if (digit)
                    begin
                        digit_acc = 32'(c - CH_ZERO);
                        mode_s    = MODE_DIGITS;
                    end
                    else
                    begin
                        // The brace did not open a number, so it passes, and
                        // the new character is taken on its own.
                        mode_s = MODE_TEXT;
                        err    = emit_plain(CH_OPEN);
                        if (err == ERR_NONE)
                        begin
                            if (c == CH_OPEN)
                                mode_s = MODE_BRACE;
                            else
                                err = emit_plain(c);
                        end
                    end
                end
                MODE_DIGITS:
                begin
                    if (digit)
                    begin
                        // Saturate just above the limit so huge strings stay
                        // flagged as overflow.
                        grown     = 64'(digit_acc) * 64'd10 + 64'(c - CH_ZERO);
                        digit_acc = (grown > FRAME_LIMIT) ? 32'(FRAME_LIMIT + 64'd1)
                                                          : 32'(grown);
                    end
                    else if (c == CH_CLOSE)
                        err = emit_tag(shift);
                    else
                        mode_s = MODE_SKIP;
                end
                MODE_SKIP:
                begin
                    if (c == CH_CLOSE)
                        err = emit_tag(shift);
                end
                default:
                begin
                    if (c == CH_OPEN)
                        mode_s = MODE_BRACE;
                    else
                        err = emit_plain(c);
                end
            endcase
        end
        // An error replaces whatever the item had produced with one item
        // carrying the code, and holds until end of text.
        if (err != ERR_NONE)
        begin
            err_held  = 1'b1;
            held_code = err;
            item_out_q.delete();
            item_out_q.push_back('{CH_NUL, err, 1'b0});
        end
        n = item_out_q.size();
        for (int i = 0; i < n; i++)
            shifted_q.push_back('{item_out_q[i].ch, item_out_q[i].status, i == n - 1});
        if (eot)
            clear_stream();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Both sides stall on about 37 percent of their chances to move, except for a
    // stretch of items in the middle of the run where they never do.
    function automatic bit idle_now();
        if (items_taken >= 60 && items_taken < 100)
            return 1'b0;
        return $urandom_range(0, 99) < 37;
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c);
        text_q.push_back('{1'b0, c});
        queued_items++;
    endtask

    // The character field is ignored at end of text, so it carries noise.
    task automatic push_eot();
        text_q.push_back('{1'b1, CHAR_W'($urandom_range(0, 255))});
        queued_items++;
    endtask

    task automatic push_string(input string s);
        foreach (s[i])
            push_char(s[i]);
    endtask

    // Printable character that is never a brace.
    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(32, 126));
        while (c == CH_OPEN || c == CH_CLOSE);
        return c;
    endfunction

    // A frame tag; the padded form adds a leading zero and trailing text
    // that the block has to skip.
    task automatic push_tag(input int unsigned value, input bit padded);
        push_char(CH_OPEN);
        if (padded)
            push_char(CH_ZERO);
        push_string($sformatf("%0d", value));
        if (padded)
            push_string(" x9");
        push_char(CH_CLOSE);
    endtask

    // One random caption line. Most are well formed so the checks on the
    // frame pair are reached; the rest break the format or are plain noise.
    task automatic add_random_line();
        int          kind;
        int unsigned first;
        kind  = $urandom_range(0, 99);
        first = $urandom_range(0, 5000);
        repeat ($urandom_range(0, 3))
            push_char(plain_char());
        if (kind < 60)
        begin
            push_tag(first, $urandom_range(0, 7) == 0);
            first = first + $urandom_range(0, 300);
            push_tag(first, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) == 0)
                push_tag(first + $urandom_range(0, 50), 1'b0);
            repeat ($urandom_range(1, 5))
                push_char(plain_char());
            push_char(CH_NL);
            if ($urandom_range(0, 4) == 0)
                push_eot();
        end
        else if (kind < 68)
        begin
            // Start frame with no end frame before ordinary text.
            push_tag(first, 1'b0);
            push_char(plain_char());
            push_eot();
        end
        else if (kind < 74)
        begin
            // End frame before the start frame.
            push_tag(first + $urandom_range(1, 100), 1'b0);
            push_tag(first, 1'b0);
            push_char(CH_NL);
            push_eot();
        end
        else if (kind < 78)
        begin
            // Text ends inside a number.
            push_char(CH_OPEN);
            repeat ($urandom_range(1, 4))
                push_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0)
                push_char(plain_char());
            push_eot();
        end
        else if (kind < 86)
        begin
            // Numbers near or past the largest frame number.
            if ($urandom_range(0, 1) == 0)
            begin
                push_char(CH_OPEN);
                repeat ($urandom_range(9, 13))
                    push_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
                push_char(CH_CLOSE);
            end
            else
                push_tag(32'h7FFF_FFFF - $urandom_range(0, 30_000_000), 1'b0);
            push_eot();
        end
        else
        begin
            // Raw bytes over the whole character range.
            repeat ($urandom_range(1, 6))
                push_char(CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                push_eot();
        end
    endtask

    task automatic add_random_lines(input int count);
        int mark;
        mark = queued_items;
        while (queued_items - mark < count)
            add_random_line();
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int delay, input int rate);
        reg_write(REG_DELAY_MS, APB_DW'(delay));
        reg_write(REG_FRAME_RATE, APB_DW'(rate));
        cfg_delay = delay[DELAY_W-1:0];
        cfg_rate  = rate[RATE_W-1:0];
    endtask

    // Waits until every item is taken and every expected item has come back,
    // then for the drain time, so the block is idle for the next write. The
    // check runs on the falling edge, after the driver and monitor have moved.
    task automatic wait_quiet();
        while (text_q.size() != 0 || char_if.valid || shifted_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock, driver and monitor
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // The driver holds an item until it is taken. Prediction happens at the
    // edge that accepts the item, from the values that were on the channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_if.valid   <= 1'b0;
            char_if.action  <= 1'b0;
            char_if.in_char <= '0;
        end
        else
        begin
            if (char_if.valid && char_if.ready)
            begin
                rewrite_item(char_if.action, char_if.in_char);
                items_taken++;
            end
            if (!char_if.valid || char_if.ready)
            begin
                if (text_q.size() != 0 && !idle_now())
                begin
                    next_item = text_q.pop_front();
                    char_if.valid   <= 1'b1;
                    char_if.action  <= next_item.eot;
                    char_if.in_char <= next_item.ch;
                end
                else
                    char_if.valid <= 1'b0;
            end
        end
    end

    // The monitor drives the result side ready and checks every item taken
    // against the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (shifted_q.size() == 0)
                begin
                    $error("result item with none expected: out_char %0h status %0d last %0b",
                           res_if.out_char, res_if.status, res_if.last);
                    failed = 1'b1;
                end
                else
                begin
                    want = shifted_q.pop_front();
                    if (res_if.out_char !== want.ch)
                    begin
                        $error("out_char: expected %0h, got %0h", want.ch, res_if.out_char);
                        failed = 1'b1;
                    end
                    if (res_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_if.status);
                        failed = 1'b1;
                    end
                    if (res_if.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res_if.last);
                        failed = 1'b1;
                    end
                end
            end
            res_if.ready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_delay    = '0;
        cfg_rate     = '0;
        queued_items = 0;
        items_taken  = 0;
        failed       = 1'b0;
        clear_stream();
        rst_n <= 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with a shift of 24 frames.
        set_config(1000, 24);
        // A full caption whose end tag skips an 0xFF byte, then a NUL byte.
        push_string("{7}{12");
        push_char(8'hFF);
        push_char(CH_CLOSE);
        push_char(CH_NUL);
        // A brace before another brace, then a brace before a letter.
        push_string("{{q");
        // A brace right before end of text; the newline gets appended.
        push_char(CH_OPEN);
        push_eot();
        // End frame before start frame; the error is repeated at end of text.
        push_string("{9}{3}Z");
        push_eot();
        // Text ending inside a number.
        push_string("{5");
        push_eot();
        wait_quiet();

        // Large shift: delay 86_400_000 at rate 240.
        set_config(86_400_000, 240);
        add_random_lines(20);
        wait_quiet();

        // Large negative delay: every item reports a negative offset.
        set_config(-86_400_000, 240);
        add_random_lines(6);
        wait_quiet();

        // Zero delay and then zero rate both pass text straight through.
        set_config(0, 240);
        add_random_lines(6);
        wait_quiet();
        set_config(123_456, 0);
        add_random_lines(6);
        wait_quiet();

        set_config($urandom_range(1, 86_400_000), $urandom_range(1, 240));
        add_random_lines(20);
        wait_quiet();

        // Delays under a tenth of a second in either direction shift by zero.
        set_config(99, 30);
        add_random_lines(8);
        wait_quiet();
        set_config(-99, 1);
        add_random_lines(8);
        wait_quiet();

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
design/ftss_pkg.sv
design/ftss_if.sv
design/ftss_ctrl.sv
design/ftss_dp.sv
design/frame_tag_subtitle_shifter.sv
tb/sv/testbench.sv
